// ===== rtl/uoi_pkg.sv =====
// Shared types, constants and the control-store program of the odometry integrator.
// Used by uoi_cordic, unicycle_odometry_integrator and the testbench; depends on nothing else.
`default_nettype none

package uoi_pkg;

  // CORDIC start value: the limit gain 0.60725293 in Q2.30.
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  // round(2^32 / (2*pi)): radians to 2^-32 turns.
  localparam longint RAD_TO_TURN32 = 64'sd683565276;

  // Arctangent of 2^-i in 2^-32 turn units, for i = 0 .. 23.
  localparam int unsigned ATAN_DEPTH = 24;
  localparam longint ATAN_TURN32 [ATAN_DEPTH] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
    64'sd21354465, 64'sd10680862, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722,
    64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
    64'sd652, 64'sd326, 64'sd163, 64'sd81
  };

  // Request codes on the command field.
  localparam logic CMD_SET_VELOCITY = 1'b0;
  localparam logic CMD_STEP         = 1'b1;

  // Control of the CORDIC unit for one step of the program.
  typedef struct packed {
    logic init;    // load the folded heading and the start vector
    logic iter;    // one micro-rotation
    logic negate;  // undo the half-turn fold
  } cordic_ctrl_t;

  // Operand pair routed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DT_SPEED,
    MUL_DT_TURN,
    MUL_DV_COS,
    MUL_DV_SIN,
    MUL_DW_RAD
  } mul_sel_t;

  // How the step counter moves on.
  typedef enum logic [1:0] {
    SEQ_GO,        // go to the target step
    SEQ_WAIT_IN,   // wait for a step request, then go to the target
    SEQ_LOOP,      // repeat until the CORDIC is on its last rotation
    SEQ_WAIT_OUT   // hold until the output register is free
  } seq_t;

  // Program steps.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DV,
    ST_MUL_DW,
    ST_ROTATE,
    ST_NEGATE,
    ST_MUL_COS,
    ST_ADD_X,
    ST_MUL_SIN,
    ST_ADD_Y,
    ST_MUL_TURN,
    ST_ADD_HEAD,
    ST_EMIT
  } step_t;

  // One control word.
  typedef struct packed {
    mul_sel_t     mul_sel;
    logic         ld_dv;
    logic         ld_dw;
    cordic_ctrl_t cordic;
    logic         upd_x;
    logic         upd_y;
    logic         upd_head;
    logic         emit;
    seq_t         seq;
    step_t        target;
  } uword_t;

  // Control store: one word per program step.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    w.mul_sel = MUL_NONE;
    w.seq     = SEQ_GO;
    w.target  = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.seq    = SEQ_WAIT_IN;
        w.target = ST_MUL_DV;
      end
      ST_MUL_DV: begin
        w.mul_sel     = MUL_DT_SPEED;
        w.cordic.init = 1'b1;
        w.target      = ST_MUL_DW;
      end
      ST_MUL_DW: begin
        w.mul_sel = MUL_DT_TURN;
        w.ld_dv   = 1'b1;
        w.target  = ST_ROTATE;
      end
      ST_ROTATE: begin
        w.ld_dw       = 1'b1;
        w.cordic.iter = 1'b1;
        w.seq         = SEQ_LOOP;
        w.target      = ST_NEGATE;
      end
      ST_NEGATE: begin
        w.cordic.negate = 1'b1;
        w.target        = ST_MUL_COS;
      end
      ST_MUL_COS: begin
        w.mul_sel = MUL_DV_COS;
        w.target  = ST_ADD_X;
      end
      ST_ADD_X: begin
        w.upd_x  = 1'b1;
        w.target = ST_MUL_SIN;
      end
      ST_MUL_SIN: begin
        w.mul_sel = MUL_DV_SIN;
        w.target  = ST_ADD_Y;
      end
      ST_ADD_Y: begin
        w.upd_y  = 1'b1;
        w.target = ST_MUL_TURN;
      end
      ST_MUL_TURN: begin
        w.mul_sel = MUL_DW_RAD;
        w.target  = ST_ADD_HEAD;
      end
      ST_ADD_HEAD: begin
        w.upd_head = 1'b1;
        w.target   = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.seq    = SEQ_WAIT_OUT;
        w.target = ST_IDLE;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/unicycle_odometry_integrator.sv =====
// Top level of the unicycle dead-reckoning integrator: control store sequencer and datapath.
// Depends on uoi_pkg and instantiates uoi_cordic.
`default_nettype none

// A request with command 0 stores the forward speed and yaw rate and gives no result;
// the sequencer stays ready for the next request. A request with command 1 applies
// one Euler step to the pose using the heading from before the step and gives one
// result: position in Q16.16 (saturating), the wrapped 16-bit heading and the stored
// velocities. A step request keeps the sequencer busy until it is done, so no new
// request is taken meanwhile; the CORDIC rotations, one per cycle, and five passes
// through a single shared 32x32 multiplier set how long that takes. The result sits
// in an output register, so the next request is taken while it waits; a step that
// finishes while an earlier result is still unread holds in its emit step until that
// result is taken.
module unicycle_odometry_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  logic         command,
  input  wire  logic signed [15:0] linear_speed,
  input  wire  logic signed [15:0] turn_rate,
  input  wire  logic [15:0]  step_dt,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic signed [15:0] speed_out,
  output logic signed [15:0] turn_out
);
  import uoi_pkg::*;

  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;
  localparam logic signed [63:0] POS_RND = 64'sd1 <<< 37;
  localparam logic signed [63:0] HEAD_RND = 64'sd1 <<< 39;

  // Sequencer.
  step_t  step;
  step_t  step_next;
  uword_t uw;

  // Architectural state.
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic [15:0]        heading_angle;
  logic signed [15:0] speed_store;
  logic signed [15:0] turn_store;

  // Working registers.
  logic [15:0]        dt;
  logic signed [31:0] dv;
  logic signed [31:0] dw;
  logic signed [63:0] prod;

  logic               accept;
  logic               out_free;
  logic               cordic_last;
  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] pos_round;
  logic signed [63:0] pos_delta;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [63:0] head_round;
  logic signed [63:0] head_units;

  uoi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (uw.cordic),
    .angle   (heading_angle),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30),
    .last    (cordic_last)
  );

  // Control word of the current step; no request is taken while in reset.
  always_comb begin
    uw       = ucode(step);
    in_ready = !rst && (uw.seq == SEQ_WAIT_IN);
    accept   = in_valid && in_ready;
    out_free = !out_valid || out_ready;
  end

  // Next step.
  always_comb begin
    step_next = step;
    unique case (uw.seq)
      SEQ_GO:       step_next = uw.target;
      SEQ_WAIT_IN:  if (accept && command == CMD_STEP) step_next = uw.target;
      SEQ_LOOP:     if (cordic_last) step_next = uw.target;
      SEQ_WAIT_OUT: if (out_free) step_next = uw.target;
      default:      step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul_sel)
      MUL_DT_SPEED: begin
        mul_a = {16'b0, dt};
        mul_b = 32'(speed_store);
      end
      MUL_DT_TURN: begin
        mul_a = {16'b0, dt};
        mul_b = 32'(turn_store);
      end
      MUL_DV_COS: begin
        mul_a = dv;
        mul_b = cos_q30;
      end
      MUL_DV_SIN: begin
        mul_a = dv;
        mul_b = sin_q30;
      end
      MUL_DW_RAD: begin
        mul_a = dw;
        mul_b = 32'(RAD_TO_TURN32);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product, time-scaled velocities and the step time.
  always_ff @(posedge clk) begin
    if (uw.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (uw.ld_dv) begin
      dv <= prod[31:0];
    end
    if (uw.ld_dw) begin
      dw <= prod[31:0];
    end
    if (accept && command == CMD_STEP) begin
      dt <= step_dt;
    end
  end

  // Rounded displacement added to x or y with saturation.
  always_comb begin
    pos_round = prod + POS_RND;
    pos_delta = pos_round >>> 38;
    pos_sum   = (uw.upd_y ? 34'(y_position) : 34'(x_position)) + pos_delta[33:0];
    if (pos_sum > POS_MAX) begin
      pos_sat = POS_MAX[31:0];
    end else if (pos_sum < POS_MIN) begin
      pos_sat = POS_MIN[31:0];
    end else begin
      pos_sat = pos_sum[31:0];
    end
    head_round = prod + HEAD_RND;
    head_units = head_round >>> 40;
  end

  // Pose and stored velocities.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      speed_store   <= '0;
      turn_store    <= '0;
    end else begin
      if (accept && command == CMD_SET_VELOCITY) begin
        speed_store <= linear_speed;
        turn_store  <= turn_rate;
      end
      if (uw.upd_x) begin
        x_position <= pos_sat;
      end
      if (uw.upd_y) begin
        y_position <= pos_sat;
      end
      if (uw.upd_head) begin
        heading_angle <= heading_angle + head_units[15:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit && out_free) begin
      pos_x     <= x_position;
      pos_y     <= y_position;
      heading   <= heading_angle;
      speed_out <= speed_store;
      turn_out  <= turn_store;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uoi_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin of a 16-bit binary angle in Q2.30.
// Depends on uoi_pkg for the arctangent table, the gain and the control struct.
`default_nettype none

module uoi_cordic #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  uoi_pkg::cordic_ctrl_t  ctrl,
  input  wire  logic [15:0]            angle,
  output logic signed [31:0]           cos_q30,
  output logic signed [31:0]           sin_q30,
  output logic                         last
);
  import uoi_pkg::*;

  localparam int ZW     = ANGLE_BITS + 2;
  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam int IDX_W  = $clog2(ATAN_DEPTH);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1 << (ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] HALF    = ZW'(1 << (ANGLE_BITS - 1));
  localparam longint ATAN_RND = 64'sd1 <<< (31 - ANGLE_BITS);

  logic signed [33:0]   x;
  logic signed [33:0]   y;
  logic signed [ZW-1:0] z;
  logic                 negate;
  logic [ITER_W-1:0]    iter;

  logic [39:0]          angle_wide;
  logic [ANGLE_BITS-1:0] angle_scaled;
  logic signed [ZW-1:0] z_start;
  logic signed [ZW-1:0] z_folded;
  logic                 fold;
  logic signed [63:0]   atan_full;
  logic signed [ZW-1:0] atan_step;
  logic signed [33:0]   dx;
  logic signed [33:0]   dy;

  // Scale the heading to the angle datapath and fold it into a quarter turn either side.
  always_comb begin
    angle_wide   = {angle, 24'b0};
    angle_scaled = angle_wide[39 -: ANGLE_BITS];
    z_start      = {{2{angle_scaled[ANGLE_BITS-1]}}, angle_scaled};
    fold         = 1'b0;
    z_folded     = z_start;
    if (z_start > QUARTER) begin
      z_folded = z_start - HALF;
      fold     = 1'b1;
    end else if (z_start < -QUARTER) begin
      z_folded = z_start + HALF;
      fold     = 1'b1;
    end
  end

  // Arctangent of this rotation, rounded to the angle resolution.
  always_comb begin
    atan_full = (ATAN_TURN32[IDX_W'(iter)] + ATAN_RND) >>> (32 - ANGLE_BITS);
    atan_step = atan_full[ZW-1:0];
    dx        = y >>> iter;
    dy        = x >>> iter;
  end

  // Vector, residual angle and fold flag.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      x      <= 34'(CORDIC_GAIN_Q30);
      y      <= '0;
      z      <= z_folded;
      negate <= fold;
    end else if (ctrl.iter) begin
      if (!z[ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_step;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_step;
      end
    end else if (ctrl.negate && negate) begin
      x <= -x;
      y <= -y;
    end
  end

  // Rotation counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (ctrl.init) begin
      iter <= '0;
    end else if (ctrl.iter) begin
      iter <= iter + 1'b1;
    end
  end

  assign last    = (iter == ITER_W'(CORDIC_STEPS - 1));
  assign cos_q30 = x[31:0];
  assign sin_q30 = y[31:0];

endmodule

`default_nettype wire

// ===== tb/uoi_pose_checker.sv =====
// Pose checker for the unicycle odometry integrator: watches both channels, predicts each
// step result from its own copy of the pose and compares it with what the block returns.
// Depends on uoi_pkg for the request codes and the CORDIC constants.

module uoi_pose_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] turn_rate,
  input  logic [15:0]        step_dt,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [15:0]        heading,
  input  logic signed [15:0] speed_out,
  input  logic signed [15:0] turn_out,
  output int                 fail_count,
  output int                 pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import uoi_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hd;
    logic signed [15:0] spd;
    logic signed [15:0] trn;
  } pose_t;

  // Predicted pose and stored velocities.
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic [15:0]        est_heading;
  logic signed [15:0] cmd_speed;
  logic signed [15:0] cmd_turn;

  pose_t pending_poses[$];
  pose_t want;
  int    mismatches;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC on the folded heading; cos and sin come out in Q2.30.
  function automatic void rotate_to_cos_sin(input logic [15:0] ang, output longint c,
                                            output longint s);
    int     up;
    int     down;
    longint full;
    longint half;
    longint quarter;
    longint z;
    longint xv;
    longint yv;
    longint dx;
    longint dy;
    longint a;
    bit     flip;
    up      = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    down    = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    full    = longint'(1) << ANGLE_BITS;
    half    = full >>> 1;
    quarter = full >>> 2;
    z       = ((longint'(ang) << up) >> down) & (full - 1);
    xv      = CORDIC_GAIN_Q30;
    yv      = 0;
    flip    = 1'b0;
    if (z >= half) z -= full;
    if (z > quarter) begin
      z -= half;
      flip = 1'b1;
    end else if (z < -quarter) begin
      z += half;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
      a  = (ATAN_TURN32[i] + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
      dx = yv >>> i;
      dy = xv >>> i;
      if (z >= 0) begin
        xv -= dx;
        yv += dy;
        z  -= a;
      end else begin
        xv += dx;
        yv -= dy;
        z  += a;
      end
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endfunction

  // One Euler step with the heading from before the step; returns the new pose.
  function automatic pose_t integrate_step(input logic [15:0] dt);
    longint dv;
    longint dw;
    longint c;
    longint s;
    longint units;
    pose_t  p;
    dv = longint'(dt) * longint'(cmd_speed);
    dw = longint'(dt) * longint'(cmd_turn);
    rotate_to_cos_sin(est_heading, c, s);
    est_x = clamp32(longint'(est_x) + ((dv * c + (longint'(1) << 37)) >>> 38));
    est_y = clamp32(longint'(est_y) + ((dv * s + (longint'(1) << 37)) >>> 38));
    units = (dw * RAD_TO_TURN32 + (longint'(1) << 39)) >>> 40;
    est_heading = est_heading + units[15:0];
    p.x   = est_x;
    p.y   = est_y;
    p.hd  = est_heading;
    p.spd = cmd_speed;
    p.trn = cmd_turn;
    return p;
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] exp_val,
                               input logic signed [63:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Results are checked before new requests are taken in, since a result accepted
  // on the same edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (rst) begin
      est_x       = '0;
      est_y       = '0;
      est_heading = '0;
      cmd_speed   = '0;
      cmd_turn    = '0;
      mismatches  = 0;
      pending_poses.delete();
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_poses.size() == 0) begin
          $display("%0t: unexpected result: x %0d, y %0d, heading %0d", $time, pos_x, pos_y,
                   heading);
          mismatches++;
        end else begin
          want = pending_poses.pop_front();
          compare_field("pos_x", want.x, pos_x);
          compare_field("pos_y", want.y, pos_y);
          compare_field("heading", want.hd, heading);
          compare_field("speed_out", want.spd, speed_out);
          compare_field("turn_out", want.trn, turn_out);
        end
      end
      if (in_valid && in_ready) begin
        if (command == CMD_STEP) begin
          pending_poses.push_back(integrate_step(step_dt));
        end else begin
          cmd_speed = linear_speed;
          cmd_turn  = turn_rate;
        end
      end
      fail_count      <= mismatches;
      pending_results <= pending_poses.size();
    end
  end

endmodule

// ===== tb/unicycle_odometry_integrator_tb.sv =====
// Top of the odometry integrator testbench: clock, reset, request and result stimulus.
// Instantiates unicycle_odometry_integrator and uoi_pose_checker; uses uoi_pkg.

module unicycle_odometry_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uoi_pkg::*;

  localparam int STEPS = 16;
  localparam int ABITS = 16;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  logic [15:0]        step_dt;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [15:0] speed_out;
  logic signed [15:0] turn_out;
  int                 fail_count;
  int                 pending_results;

  bit send_burst;
  int sent_count;
  bit recv_burst;
  int taken_count;

  unicycle_odometry_integrator #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .linear_speed(linear_speed),
    .turn_rate   (turn_rate),
    .step_dt     (step_dt),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .speed_out   (speed_out),
    .turn_out    (turn_out)
  );

  uoi_pose_checker #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .linear_speed   (linear_speed),
    .turn_rate      (turn_rate),
    .step_dt        (step_dt),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .heading        (heading),
    .speed_out      (speed_out),
    .turn_out       (turn_out),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one request, after a random gap unless in a burst, and hold it until it is accepted.
  task automatic offer(input logic cmd, input logic signed [15:0] v,
                       input logic signed [15:0] w, input logic [15:0] dt);
    int gap;
    if (sent_count % 32 == 0) send_burst = ($urandom_range(3) == 0);
    sent_count++;
    gap = send_burst ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    linear_speed <= v;
    turn_rate    <= w;
    step_dt      <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Velocity requests carry a random step time and step requests random speeds,
  // since the block ignores those fields.
  task automatic send_velocity(input logic signed [15:0] v, input logic signed [15:0] w);
    offer(CMD_SET_VELOCITY, v, w, 16'($urandom));
  endtask

  task automatic send_step(input logic [15:0] dt);
    offer(CMD_STEP, 16'($urandom), 16'($urandom), dt);
  endtask

  // Stop offering and wait until every predicted pose has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_rate();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stalls, two long hold-offs that back the block up.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken_count % 32 == 0) recv_burst = ($urandom_range(3) == 0);
      gap = recv_burst ? 0 : $urandom_range(7);
      if (taken_count == 40 || taken_count == 400) gap = 200;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken_count++;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    command      <= CMD_SET_VELOCITY;
    linear_speed <= '0;
    turn_rate    <= '0;
    step_dt      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: zero state, zero step time, speed and turn extremes, heading wrap.
    // The turns are paired so that the heading ends close to zero.
    send_step(16'h0000);
    send_step(16'hFFFF);
    send_velocity(16'sh7FFF, 16'sd0);
    send_step(16'h0000);
    send_step(16'h0001);
    send_step(16'hFFFF);
    send_velocity(16'sh8000, 16'sd0);
    send_step(16'hFFFF);
    send_velocity(16'sd256, 16'sh7FFF);
    send_step(16'hFFFF);
    send_velocity(-16'sd1, -16'sh7FFF);
    send_step(16'hFFFF);
    send_velocity(16'sh7FFF, 16'sh8000);
    send_step(16'h8000);
    send_velocity(16'sd0, 16'sh7FFF);
    send_step(16'h8000);
    send_velocity(16'sd1, 16'sd1);
    send_step(16'hFFFF);
    send_velocity(16'sh8000, -16'sd1);
    send_step(16'hFFFF);
    wait_for_results();

    // Full speed along x until the position saturates high, then a quarter turn
    // clockwise and full speed until y saturates low.
    send_velocity(16'sh7FFF, 16'sd0);
    repeat (290) send_step(16'($urandom_range(65535, 63000)));
    send_velocity(16'sd0, -16'sd402);
    send_step(16'hFFFF);
    send_velocity(16'sh7FFF, 16'sd0);
    repeat (290) send_step(16'($urandom_range(65535, 63000)));
    wait_for_results();

    // Random mix of velocity and step requests.
    repeat (260) begin
      if ($urandom_range(63) == 0) wait_for_results();
      if ($urandom_range(2) == 0) send_velocity(pick_rate(), pick_rate());
      else send_step(pick_dt());
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uoi_pkg.sv
rtl/uoi_cordic.sv
rtl/unicycle_odometry_integrator.sv
tb/uoi_pose_checker.sv
tb/unicycle_odometry_integrator_tb.sv
